### hdl/tdqs_pkg.sv
// Package for the term deque with search.
// Holds sizes, mode, status, state and cell operation codes, and the cell control struct.
`timescale 1ns / 1ps

package tdqs_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int STAT_W   = 2;

   typedef enum logic [2:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_BACK   = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_REMOVE     = 3'd4,
      MODE_FIND       = 3'd5,
      MODE_LOOKUP     = 3'd6
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_PUSH_FRONT,
      CELL_POP_FRONT,
      CELL_MARK_EXACT,
      CELL_MARK_DEG,
      CELL_MARK_LAST,
      CELL_MARK_FIRST,
      CELL_COMPACT
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SCAN,
      ST_COMPACT,
      ST_DONE
   } state_type;

   typedef struct packed {
      cell_op_type               op;
      logic [CNT_W-1:0]          count;
      logic signed [DATA_W-1:0]  deg;
      logic signed [DATA_W-1:0]  coef;
   } cell_ctl_type;

endpackage

### hdl/tdqs_cell.sv
// One slot of the deque chain: holds an entry and a match mark.
// Shifts with its neighbors; depends on tdqs_pkg.
`timescale 1ns / 1ps

module tdqs_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  tdqs_pkg::cell_ctl_type            ctl,
   input  logic [tdqs_pkg::IDX_W-1:0]        cell_idx,
   input  logic signed [tdqs_pkg::DATA_W-1:0] prev_deg,
   input  logic signed [tdqs_pkg::DATA_W-1:0] prev_coef,
   input  logic signed [tdqs_pkg::DATA_W-1:0] next_deg,
   input  logic signed [tdqs_pkg::DATA_W-1:0] next_coef,
   input  logic                              next_mark,
   input  logic                              hole_in,
   output logic                              hole_out,
   output logic                              first,
   output logic                              mark,
   output logic signed [tdqs_pkg::DATA_W-1:0] deg,
   output logic signed [tdqs_pkg::DATA_W-1:0] coef
);

   logic signed [tdqs_pkg::DATA_W-1:0] deg_ff, deg_in;
   logic signed [tdqs_pkg::DATA_W-1:0] coef_ff, coef_in;
   logic                              mark_ff, mark_in;
   logic [tdqs_pkg::CNT_W-1:0]        pos;
   logic                              valid;

   assign pos      = tdqs_pkg::CNT_W'(cell_idx);
   assign valid    = pos < ctl.count;
   assign hole_out = hole_in | mark_ff;
   assign first    = mark_ff & ~hole_in;
   assign mark     = mark_ff;
   assign deg      = deg_ff;
   assign coef     = coef_ff;

   always_comb begin
      deg_in  = deg_ff;
      coef_in = coef_ff;
      mark_in = mark_ff;
      unique case (ctl.op)
         tdqs_pkg::CELL_WRITE: begin
            if (pos == ctl.count) begin
               deg_in  = ctl.deg;
               coef_in = ctl.coef;
            end
         end
         tdqs_pkg::CELL_PUSH_FRONT: begin
            deg_in  = prev_deg;
            coef_in = prev_coef;
         end
         tdqs_pkg::CELL_POP_FRONT: begin
            deg_in  = next_deg;
            coef_in = next_coef;
         end
         tdqs_pkg::CELL_MARK_EXACT: mark_in = valid && deg_ff == ctl.deg && coef_ff == ctl.coef;
         tdqs_pkg::CELL_MARK_DEG:   mark_in = valid && deg_ff == ctl.deg;
         tdqs_pkg::CELL_MARK_LAST:  mark_in = valid && (pos + 1'b1) == ctl.count;
         tdqs_pkg::CELL_MARK_FIRST: mark_in = valid && cell_idx == '0;
         tdqs_pkg::CELL_COMPACT: begin
            if (hole_out) begin
               deg_in  = next_deg;
               coef_in = next_coef;
               mark_in = next_mark;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      deg_ff  <= deg_in;
      coef_ff <= coef_in;
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

endmodule

### hdl/term_deque_with_search_unit.sv
// Flow: an accepted request goes through the mark and scan states, then,
// for remove-all only, the compact state, and waits in done to publish its result.
// One request at a time: a new one stalls until the last result is published;
// the compaction walk in the cell chain closes one hole per cycle.
// Reset: synchronous; deque empty, no result pending, entries undefined until written.
// Top level of the term deque with search; depends on tdqs_pkg and tdqs_cell.
`timescale 1ns / 1ps

module term_deque_with_search_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_in_degree,
   input  logic signed [31:0]  req_in_coef,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_out_degree,
   output logic signed [31:0]  rsp_out_coef,
   output logic signed [4:0]   rsp_position,
   output logic [4:0]          rsp_removed_count
);

   localparam int N = tdqs_pkg::CAPACITY;
   localparam int W = tdqs_pkg::DATA_W;

   tdqs_pkg::state_type            state_ff, state_in;
   tdqs_pkg::mode_type             mode_ff, mode_in;
   logic signed [W-1:0]            op_deg_ff, op_deg_in, op_coef_ff, op_coef_in;
   logic [tdqs_pkg::CNT_W-1:0]     count_ff, count_in, removed_ff, removed_in;
   tdqs_pkg::status_type           status_ff, status_in;
   logic signed [W-1:0]            res_deg_ff, res_deg_in, res_coef_ff, res_coef_in;
   logic [tdqs_pkg::POS_W-1:0]     res_pos_ff, res_pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic signed [W-1:0]            rsp_deg_ff, rsp_deg_in, rsp_coef_ff, rsp_coef_in;
   logic [4:0]                     rsp_pos_ff, rsp_pos_in, rsp_cnt_ff, rsp_cnt_in;

   tdqs_pkg::cell_op_type          cell_op;
   tdqs_pkg::cell_ctl_type         ctl;
   logic signed [W-1:0]            deg_w [N];
   logic signed [W-1:0]            coef_w [N];
   logic                           mark_w [N];
   logic                           first_w [N];
   logic                           hole_w [N+1];
   logic signed [W-1:0]            sel_deg, sel_coef;
   logic [tdqs_pkg::IDX_W-1:0]     sel_idx;
   logic                           any_mark, full, empty, accept, publish;

   assign ctl.op    = cell_op;
   assign ctl.count = count_ff;
   assign ctl.deg   = op_deg_ff;
   assign ctl.coef  = op_coef_ff;
   assign hole_w[0] = 1'b0;
   assign any_mark  = hole_w[N];
   assign full      = count_ff == tdqs_pkg::CNT_W'(N);
   assign empty     = count_ff == '0;
   assign req_stall = state_ff != tdqs_pkg::ST_IDLE;
   assign accept    = req_valid & ~req_stall;
   assign publish   = ~rsp_valid_ff | ~rsp_stall;

   for (genvar i = 0; i < N; i++) begin : g_cell
      tdqs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .cell_idx  (tdqs_pkg::IDX_W'(i)),
         .prev_deg  ((i == 0) ? op_deg_ff : deg_w[(i == 0) ? 0 : i-1]),
         .prev_coef ((i == 0) ? op_coef_ff : coef_w[(i == 0) ? 0 : i-1]),
         .next_deg  ((i == N-1) ? '0 : deg_w[(i == N-1) ? i : i+1]),
         .next_coef ((i == N-1) ? '0 : coef_w[(i == N-1) ? i : i+1]),
         .next_mark ((i == N-1) ? 1'b0 : mark_w[(i == N-1) ? i : i+1]),
         .hole_in   (hole_w[i]),
         .hole_out  (hole_w[i+1]),
         .first     (first_w[i]),
         .mark      (mark_w[i]),
         .deg       (deg_w[i]),
         .coef      (coef_w[i])
      );
   end

   always_comb begin
      sel_deg  = '0;
      sel_coef = '0;
      sel_idx  = '0;
      for (int i = 0; i < N; i++) begin
         if (first_w[i]) begin
            sel_deg  = sel_deg | deg_w[i];
            sel_coef = sel_coef | coef_w[i];
            sel_idx  = sel_idx | tdqs_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdqs_pkg::ST_IDLE:    if (accept) state_in = tdqs_pkg::ST_MARK;
         tdqs_pkg::ST_MARK:    state_in = tdqs_pkg::ST_SCAN;
         tdqs_pkg::ST_SCAN:    state_in = (mode_ff == tdqs_pkg::MODE_REMOVE) ?
                                          tdqs_pkg::ST_COMPACT : tdqs_pkg::ST_DONE;
         tdqs_pkg::ST_COMPACT: if (!any_mark) state_in = tdqs_pkg::ST_DONE;
         tdqs_pkg::ST_DONE:    if (publish) state_in = tdqs_pkg::ST_IDLE;
         default:              state_in = tdqs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cell_op       = tdqs_pkg::CELL_HOLD;
      mode_in       = mode_ff;
      op_deg_in     = op_deg_ff;
      op_coef_in    = op_coef_ff;
      count_in      = count_ff;
      removed_in    = removed_ff;
      status_in     = status_ff;
      res_deg_in    = res_deg_ff;
      res_coef_in   = res_coef_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_deg_in    = rsp_deg_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      unique case (state_ff)
         tdqs_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in     = tdqs_pkg::mode_type'(req_mode);
               op_deg_in   = req_in_degree;
               op_coef_in  = req_in_coef;
               removed_in  = '0;
               status_in   = tdqs_pkg::STAT_OK;
               res_deg_in  = '0;
               res_coef_in = '0;
               res_pos_in  = '0;
            end
         end
         tdqs_pkg::ST_MARK: begin
            unique case (mode_ff)
               tdqs_pkg::MODE_PUSH_BACK, tdqs_pkg::MODE_PUSH_FRONT: begin
                  if (full) begin
                     status_in = tdqs_pkg::STAT_FULL;
                  end else begin
                     cell_op  = (mode_ff == tdqs_pkg::MODE_PUSH_BACK) ?
                                tdqs_pkg::CELL_WRITE : tdqs_pkg::CELL_PUSH_FRONT;
                     count_in = count_ff + 1'b1;
                  end
               end
               tdqs_pkg::MODE_POP_BACK, tdqs_pkg::MODE_POP_FRONT: begin
                  if (empty) begin
                     status_in = tdqs_pkg::STAT_EMPTY;
                  end else begin
                     cell_op = (mode_ff == tdqs_pkg::MODE_POP_BACK) ?
                               tdqs_pkg::CELL_MARK_LAST : tdqs_pkg::CELL_MARK_FIRST;
                  end
               end
               tdqs_pkg::MODE_REMOVE, tdqs_pkg::MODE_FIND: cell_op = tdqs_pkg::CELL_MARK_EXACT;
               tdqs_pkg::MODE_LOOKUP: cell_op = tdqs_pkg::CELL_MARK_DEG;
               default: ;
            endcase
         end
         tdqs_pkg::ST_SCAN: begin
            unique case (mode_ff)
               tdqs_pkg::MODE_POP_BACK, tdqs_pkg::MODE_POP_FRONT: begin
                  if (status_ff == tdqs_pkg::STAT_OK) begin
                     res_deg_in  = sel_deg;
                     res_coef_in = sel_coef;
                     count_in    = count_ff - 1'b1;
                     if (mode_ff == tdqs_pkg::MODE_POP_FRONT) begin
                        cell_op = tdqs_pkg::CELL_POP_FRONT;
                     end
                  end
               end
               tdqs_pkg::MODE_FIND:   res_pos_in = any_mark ?
                                                   tdqs_pkg::POS_W'(sel_idx) : '1;
               tdqs_pkg::MODE_LOOKUP: res_coef_in = sel_coef;
               default: ;
            endcase
         end
         tdqs_pkg::ST_COMPACT: begin
            if (any_mark) begin
               cell_op    = tdqs_pkg::CELL_COMPACT;
               count_in   = count_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
            end
         end
         tdqs_pkg::ST_DONE: begin
            if (publish) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_deg_in    = res_deg_ff;
               rsp_coef_in   = res_coef_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_cnt_in    = 5'(removed_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdqs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      op_deg_ff     <= op_deg_in;
      op_coef_ff    <= op_coef_in;
      removed_ff    <= removed_in;
      status_ff     <= status_in;
      res_deg_ff    <= res_deg_in;
      res_coef_ff   <= res_coef_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_deg_ff    <= rsp_deg_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_degree    = rsp_deg_ff;
   assign rsp_out_coef      = rsp_coef_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_removed_count = rsp_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tdqs_pkg::CNT_W'(N))
      else $error("fill count above capacity");

   a_compact_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdqs_pkg::ST_COMPACT && any_mark) |-> count_ff != '0)
      else $error("hole found in empty deque");

   a_publish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdqs_pkg::ST_DONE && publish) |=> rsp_valid_ff)
      else $error("result beat lost");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdqs_pkg::ST_MARK && full &&
       (mode_ff == tdqs_pkg::MODE_PUSH_BACK || mode_ff == tdqs_pkg::MODE_PUSH_FRONT))
      |=> $stable(count_ff))
      else $error("push on full deque changed fill count");

endmodule
